@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the terminal engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/ttce_pkg.sv @@
// ----------------------------------------------------------------------------
// ttce_pkg
// Types and constants shared by the text terminal cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ttce_pkg;

    localparam int ROW_FIELD_W = 5;
    localparam int COL_FIELD_W = 7;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NULL      = 8'h00;

    localparam logic [7:0] COLOR_RESET = 8'h0F;

    typedef struct packed {
        logic [1:0]             operation;
        logic [7:0]             char_code;
        logic [ROW_FIELD_W-1:0] cell_row;
        logic [COL_FIELD_W-1:0] cell_col;
    } in_t;

    typedef struct packed {
        logic [15:0]            cell_value;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_col;
    } out_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic                   scroll;
        logic [15:0]            wdata;
        logic [ROW_FIELD_W-1:0] cursor_row;
        logic [COL_FIELD_W-1:0] cursor_col;
    } cmd_ctl_t;

    typedef enum logic [2:0] {
        BK_INIT,
        BK_IDLE,
        BK_READ,
        BK_FILL,
        BK_COPY,
        BK_BLANK
    } back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/ttce_front.sv @@
// ----------------------------------------------------------------------------
// ttce_front
// Accepts requests, tracks the cursor and the color register, and turns each
// request into one screen command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ttce_front #(
    parameter int ROWS      = 25,
    parameter int COLUMNS   = 80,
    parameter int TAB_WIDTH = 8,
    parameter int ADDR_W    = 11
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ttce_pkg::in_t     s_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data,
    input  wire logic              init_busy,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output ttce_pkg::cmd_ctl_t     push_ctl,
    output logic [ADDR_W-1:0]      push_addr,
    output logic [7:0]             color
);
    import ttce_pkg::*;

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int PH_W  = $clog2(TAB_WIDTH);
    localparam int SUM_W = $clog2(COLUMNS + TAB_WIDTH);

    logic [ROW_W-1:0]  row_reg,   row_next;
    logic [COL_W-1:0]  col_reg,   col_next;
    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [7:0]        color_reg;
    logic [SUM_W-1:0]  col_sum;
    logic              row_step;
    logic [ADDR_W-1:0] here_addr;
    logic [ADDR_W-1:0] read_addr;
    logic [PH_W-1:0]   phase_inc;
    logic [PH_W-1:0]   phase_dec;
    logic              accept;

    assign s_ready    = push_ready && !init_busy;
    assign push_valid = s_valid && !init_busy;
    assign accept     = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign color      = color_reg;

    assign here_addr = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign read_addr = ADDR_W'(s_data.cell_row) * ADDR_W'(COLUMNS)
                     + ADDR_W'(s_data.cell_col);
    assign phase_inc = (phase_reg == PH_W'(TAB_WIDTH - 1)) ? '0 : phase_reg + PH_W'(1);
    assign phase_dec = (phase_reg == '0) ? PH_W'(TAB_WIDTH - 1) : phase_reg - PH_W'(1);

    always_comb begin
        row_next        = row_reg;
        col_next        = col_reg;
        phase_next      = phase_reg;
        col_sum         = SUM_W'(col_reg);
        row_step        = 1'b0;
        push_ctl.kind   = CMD_NONE;
        push_ctl.scroll = 1'b0;
        push_ctl.wdata  = {color_reg, s_data.char_code};
        push_addr       = here_addr;
        case (s_data.operation)
            OP_PUT: begin
                case (s_data.char_code)
                    CH_NEWLINE: begin
                        col_sum    = '0;
                        row_step   = 1'b1;
                        phase_next = '0;
                    end
                    CH_BACKSPACE: begin
                        if (col_reg != '0) begin
                            push_ctl.kind  = CMD_WRITE;
                            push_addr      = here_addr - ADDR_W'(1);
                            push_ctl.wdata = {color_reg, CH_SPACE};
                            col_sum        = SUM_W'(col_reg) - SUM_W'(1);
                            phase_next     = phase_dec;
                        end
                    end
                    CH_RETURN: begin
                        col_sum    = '0;
                        phase_next = '0;
                    end
                    CH_TAB: begin
                        col_sum    = SUM_W'(col_reg) + SUM_W'(TAB_WIDTH) - SUM_W'(phase_reg);
                        phase_next = '0;
                    end
                    default: begin
                        push_ctl.kind = CMD_WRITE;
                        col_sum       = SUM_W'(col_reg) + SUM_W'(1);
                        phase_next    = phase_inc;
                    end
                endcase
                if (col_sum >= SUM_W'(COLUMNS)) begin
                    col_sum    = '0;
                    row_step   = 1'b1;
                    phase_next = '0;
                end
                if (row_step) begin
                    if (row_reg == ROW_W'(ROWS - 1)) begin
                        push_ctl.scroll = 1'b1;
                    end else begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                col_next = COL_W'(col_sum);
            end
            OP_READ: begin
                if (32'(s_data.cell_row) < ROWS && 32'(s_data.cell_col) < COLUMNS) begin
                    push_ctl.kind = CMD_READ;
                    push_addr     = read_addr;
                end
            end
            OP_CLEAR: begin
                push_ctl.kind = CMD_CLEAR;
                row_next      = '0;
                col_next      = '0;
                phase_next    = '0;
            end
            default: begin
                push_ctl.kind = CMD_NONE;
            end
        endcase
        push_ctl.cursor_row = ROW_FIELD_W'(row_next);
        push_ctl.cursor_col = COL_FIELD_W'(col_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= '0;
            col_reg   <= '0;
            phase_reg <= '0;
            color_reg <= COLOR_RESET;
        end else begin
            if (accept) begin
                row_reg   <= row_next;
                col_reg   <= col_next;
                phase_reg <= phase_next;
            end
            if (cfg_valid && cfg_ready) begin
                color_reg <= cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ttce_queue.sv @@
// ----------------------------------------------------------------------------
// ttce_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ttce_queue #(
    parameter int DEPTH  = 2,
    parameter int ADDR_W = 11
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire ttce_pkg::cmd_ctl_t push_ctl,
    input  wire logic [ADDR_W-1:0]  push_addr,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output ttce_pkg::cmd_ctl_t      pop_ctl,
    output logic [ADDR_W-1:0]       pop_addr
);
    import ttce_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_ctl_t          ctl_mem  [DEPTH];
    logic [ADDR_W-1:0] addr_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_ctl    = ctl_mem[rd_ptr_reg];
    assign pop_addr   = addr_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ctl_mem[wr_ptr_reg]  <= push_ctl;
            addr_mem[wr_ptr_reg] <= push_addr;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ttce_back.sv @@
// ----------------------------------------------------------------------------
// ttce_back
// Carries out screen commands on the cell memory: cell writes and reads,
// scroll, clear fill and the clearing pass after reset; holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ttce_back #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80,
    parameter int ADDR_W  = 11
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire ttce_pkg::cmd_ctl_t pop_ctl,
    input  wire logic [ADDR_W-1:0]  pop_addr,
    input  wire logic [7:0]         color,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ttce_pkg::out_t          m_data,
    output logic                    init_busy
);
    import ttce_pkg::*;

    localparam int TOTAL = ROWS * COLUMNS;
    localparam int CNT_W = $clog2(TOTAL + 1);

    logic [15:0]       mem [TOTAL];
    logic [15:0]       rdata_reg;

    back_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic              pend_reg,  pend_next;
    logic [ADDR_W-1:0] paddr_reg, paddr_next;
    cmd_ctl_t          hold_reg,  hold_next;
    logic              m_valid_reg, m_valid_next;
    out_t              m_data_reg,  m_data_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [ADDR_W-1:0] raddr;
    logic              out_free;
    logic              load_out;
    logic [15:0]       load_value;
    cmd_ctl_t          load_ctl;
    logic              last_cell;

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign init_busy = (state_reg == BK_INIT);
    assign out_free  = !m_valid_reg || m_ready;
    assign last_cell = (cnt_reg == CNT_W'(TOTAL - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pend_next  = 1'b0;
        paddr_next = paddr_reg;
        hold_next  = hold_reg;
        pop_ready  = 1'b0;
        we         = 1'b0;
        waddr      = cnt_reg[ADDR_W-1:0];
        wdata      = 16'h0000;
        raddr      = '0;
        load_out   = 1'b0;
        load_value = 16'h0000;
        load_ctl   = hold_reg;
        case (state_reg)
            BK_INIT: begin
                we       = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_cell) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (pop_valid && out_free) begin
                    pop_ready = 1'b1;
                    hold_next = pop_ctl;
                    load_ctl  = pop_ctl;
                    case (pop_ctl.kind)
                        CMD_READ: begin
                            raddr      = pop_addr;
                            state_next = BK_READ;
                        end
                        CMD_CLEAR: begin
                            cnt_next   = '0;
                            state_next = BK_FILL;
                        end
                        default: begin
                            if (pop_ctl.kind == CMD_WRITE) begin
                                we    = 1'b1;
                                waddr = pop_addr;
                                wdata = pop_ctl.wdata;
                            end
                            if (pop_ctl.scroll) begin
                                cnt_next   = CNT_W'(COLUMNS);
                                state_next = BK_COPY;
                            end else begin
                                load_out = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BK_READ: begin
                load_out   = 1'b1;
                load_value = rdata_reg;
                state_next = BK_IDLE;
            end
            BK_FILL: begin
                we       = 1'b1;
                wdata    = {color, CH_NULL};
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_cell) begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            BK_COPY: begin
                if (pend_reg) begin
                    we    = 1'b1;
                    waddr = paddr_reg;
                    wdata = rdata_reg;
                end
                if (cnt_reg < CNT_W'(TOTAL)) begin
                    raddr      = cnt_reg[ADDR_W-1:0];
                    pend_next  = 1'b1;
                    paddr_next = ADDR_W'(cnt_reg - CNT_W'(COLUMNS));
                    cnt_next   = cnt_reg + CNT_W'(1);
                end else begin
                    cnt_next   = CNT_W'((ROWS - 1) * COLUMNS);
                    state_next = BK_BLANK;
                end
            end
            BK_BLANK: begin
                we       = 1'b1;
                wdata    = {color, CH_SPACE};
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_cell) begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (load_out) begin
            m_valid_next           = 1'b1;
            m_data_next.cell_value = load_value;
            m_data_next.cursor_row = load_ctl.cursor_row;
            m_data_next.cursor_col = load_ctl.cursor_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_INIT;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        paddr_reg  <= paddr_next;
        hold_reg   <= hold_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/text_terminal_cursor_engine_core.sv @@
// ----------------------------------------------------------------------------
// text_terminal_cursor_engine_core: character-cell terminal with cursor
// A put, move or no-op result is registered when the back end pops the command from
// the queue; a read result waits for the registered memory read. The back end pops a
// new command only when idle and its output is free; reads, scrolls and clears stall it.
// Reset: a zero pass over all ROWS*COLUMNS cells (2000 at default) holds s_ready low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module text_terminal_cursor_engine_core #(
    parameter int ROWS        = 25,
    parameter int COLUMNS     = 80,
    parameter int TAB_WIDTH   = 8,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ttce_pkg::in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output ttce_pkg::out_t     m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_data
);
    import ttce_pkg::*;

    localparam int ADDR_W = $clog2(ROWS * COLUMNS);

    logic              init_busy;
    logic [7:0]        color;
    logic              f_valid;
    logic              f_ready;
    cmd_ctl_t          f_ctl;
    logic [ADDR_W-1:0] f_addr;
    logic              q_valid;
    logic              q_ready;
    cmd_ctl_t          q_ctl;
    logic [ADDR_W-1:0] q_addr;
    logic              cursor_ok;

    assign cursor_ok = (32'(m_data.cursor_row) < ROWS) && (32'(m_data.cursor_col) < COLUMNS);

    ttce_front #(
        .ROWS      (ROWS),
        .COLUMNS   (COLUMNS),
        .TAB_WIDTH (TAB_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .init_busy  (init_busy),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_ctl   (f_ctl),
        .push_addr  (f_addr),
        .color      (color)
    );

    ttce_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_ctl   (f_ctl),
        .push_addr  (f_addr),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_ctl    (q_ctl),
        .pop_addr   (q_addr)
    );

    ttce_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .ADDR_W  (ADDR_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_ctl   (q_ctl),
        .pop_addr  (q_addr),
        .color     (color),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .init_busy (init_busy)
    );

    `ASSERT_SAME(a_no_result_in_init, aclk, aresetn, m_valid, !init_busy)
    `ASSERT_SAME(a_cursor_on_screen, aclk, aresetn, m_valid, cursor_ok)
    `ASSERT_SAME(a_init_leaves_empty, aclk, aresetn, $fell(init_busy), !m_valid && !q_valid)
    `ASSERT_NEXT(a_no_work_in_init, aclk, aresetn, init_busy, !q_valid)

endmodule

`default_nettype wire
